/* design/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* design/ett_pkg.sv */
// types and constants of the expiry timer table
package ett_pkg;

   localparam int DEF_NUM_SLOTS = 32;
   localparam int DEF_TIME_BITS = 32;

   localparam int TICKS_W = 31;
   localparam logic [TICKS_W-1:0] TICKS_MAX = 31'h7fff_ffff;

   typedef enum logic [2:0] {
      CMD_ATTACH = 3'd0,
      CMD_MODIFY = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_RUN    = 3'd3,
      CMD_QUERY  = 3'd4,
      CMD_PURGE  = 3'd5
   } cmd_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_PEND = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MOD_CMP,
      S_WALK_RD,
      S_WALK_CHK,
      S_REM_HINT,
      S_MOD_HINT,
      S_APPEND1,
      S_APPEND2,
      S_RUN_END,
      S_TICKS,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      WK_REMOVE,
      WK_RUN,
      WK_MIN
   } walk_type;

endpackage

/* design/ett_req_if.sv */
// request and response channel interfaces
interface ett_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [4:0]  slot;
   logic [31:0] expiry_time;
   logic [31:0] current_time;
   modport source (output valid, cmd, slot, expiry_time, current_time, input ready);
   modport sink (input valid, cmd, slot, expiry_time, current_time, output ready);
endinterface

interface ett_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [30:0] ticks_left;
   logic        fired;
   logic [4:0]  fired_slot;
   logic        last;
   modport source (output valid, status, ticks_left, fired, fired_slot, last, input ready);
   modport sink (input valid, status, ticks_left, fired, fired_slot, last, output ready);
endinterface

/* design/ett_tcmp.sv */
// shared wrap-aware time compare and distance unit
module ett_tcmp import ett_pkg::*; #(
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic [TIME_BITS-1:0] a,
   input  logic [TIME_BITS-1:0] b,
   output logic [TIME_BITS-1:0] diff,
   output logic                 a_after_b
);
   // a later than b when b - a lands in the upper half
   assign diff      = b - a;
   assign a_after_b = diff[TIME_BITS-1];
endmodule

/* design/ett_store.sv */
// expiry and order link memories, one read address shared
module ett_store import ett_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS,
   localparam int SW = $clog2(NUM_SLOTS)
) (
   input  logic                 clock,
   input  logic [SW-1:0]        rd_addr,
   input  logic                 exp_we,
   input  logic [SW-1:0]        exp_wa,
   input  logic [TIME_BITS-1:0] exp_wd,
   input  logic                 lnk_we,
   input  logic [SW-1:0]        lnk_wa,
   input  logic [SW-1:0]        lnk_wd,
   output logic [TIME_BITS-1:0] exp_rd,
   output logic [SW-1:0]        lnk_rd
);
   logic [TIME_BITS-1:0] exp_mem [NUM_SLOTS];
   logic [SW-1:0]        lnk_mem [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_wa] <= exp_wd;
      end
      exp_rd <= exp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      lnk_rd <= lnk_mem[rd_addr];
   end
endmodule

/* design/expiry_timer_table.sv */
// top level of the expiry timer table
// One-shot timer table with a command sequencer. Every command takes one request word
// and gives one response word, except a run that fires k > 0 slots, which gives k words
// in arming order with last set on the final one. Attach, purge and errors go from
// decode straight to the response; modify to a new expiry and delete of an armed slot
// walk the arming list to unlink it; run and a query that rebuilds the next-expiry hint
// walk the whole list. Each walk step visits one armed slot through the single registered
// read port of the slot store, and a run step that fires stalls while the output register is full. Requests are
// taken only while the sequencer is idle; a finished response waits in an output
// register while the next request is taken. Times wrap at TIME_BITS bits and are
// compared wrap-aware with half the range as horizon; all wrap-aware compares and
// distances go through one shared time unit. No clearing pass is needed after reset.
module expiry_timer_table import ett_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input logic     clock,
   input logic     reset,
   ett_req_if.sink   req_chan,
   ett_rsp_if.source rsp_chan
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = SW + 1;
   localparam logic [TIME_BITS-1:0] HALF = {1'b0, {(TIME_BITS-1){1'b1}}};

   // sequencer state
   state_type state_ff, state_in;
   walk_type  mode_ff, mode_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [4:0]           slot_ff, slot_in;
   logic [TIME_BITS-1:0] exp_ff, exp_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic                 have_prev_ff, have_prev_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 held_valid_ff, held_valid_in;
   logic [SW-1:0]        held_slot_ff, held_slot_in;
   logic [TIME_BITS-1:0] old_exp_ff, old_exp_in;
   logic [1:0]           status_ff, status_in;
   logic [TICKS_W-1:0]   ticks_ff, ticks_in;

   // table state
   logic [NUM_SLOTS-1:0] attached_ff, attached_in;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        tail_ff, tail_in;
   logic [TIME_BITS-1:0] lrt_ff, lrt_in;
   logic [TIME_BITS-1:0] hint_ff, hint_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [TICKS_W-1:0] rsp_ticks_ff;
   logic               rsp_fired_ff;
   logic [4:0]         rsp_slot_ff;
   logic               rsp_last_ff;

   logic               load;
   logic [1:0]         ld_status;
   logic [TICKS_W-1:0] ld_ticks;
   logic               ld_fired;
   logic [4:0]         ld_slot;
   logic               ld_last;

   // store and time unit hookup
   logic [SW-1:0]        rd_addr;
   logic                 exp_we, lnk_we;
   logic [SW-1:0]        exp_wa, lnk_wa, lnk_wd;
   logic [TIME_BITS-1:0] exp_wd;
   logic [TIME_BITS-1:0] exp_rd;
   logic [SW-1:0]        lnk_rd;
   logic [TIME_BITS-1:0] cmp_a, cmp_b, cmp_diff;
   logic                 cmp_after;

   logic          out_free;
   logic          tbl_empty;
   logic          slot_ok;
   logic [SW-1:0] sidx;
   logic          cur_ok;
   logic          is_tail;
   logic          do_unlink;
   logic [63:0]   span;

   ett_store #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .exp_we  (exp_we),
      .exp_wa  (exp_wa),
      .exp_wd  (exp_wd),
      .lnk_we  (lnk_we),
      .lnk_wa  (lnk_wa),
      .lnk_wd  (lnk_wd),
      .exp_rd  (exp_rd),
      .lnk_rd  (lnk_rd)
   );

   ett_tcmp #(.TIME_BITS(TIME_BITS)) u_tcmp (
      .a         (cmp_a),
      .b         (cmp_b),
      .diff      (cmp_diff),
      .a_after_b (cmp_after)
   );

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign tbl_empty = ~|armed_ff;
   assign slot_ok   = 7'(slot_ff) < 7'(NUM_SLOTS);
   assign sidx      = SW'(slot_ff);
   assign cur_ok    = CW'(cur_ff) < CW'(NUM_SLOTS);
   assign is_tail   = cur_ff == tail_ff;
   assign span      = 64'(cmp_diff);

   assign req_chan.ready = state_ff == S_IDLE;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.ticks_left = rsp_ticks_ff;
   assign rsp_chan.fired      = rsp_fired_ff;
   assign rsp_chan.fired_slot = rsp_slot_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      cnt_in        = cnt_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      old_exp_in    = old_exp_ff;
      status_in     = status_ff;
      ticks_in      = ticks_ff;
      attached_in   = attached_ff;
      armed_in      = armed_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      lrt_in        = lrt_ff;
      hint_in       = hint_ff;

      rd_addr   = cur_ff;
      exp_we    = 1'b0;
      exp_wa    = sidx;
      exp_wd    = exp_ff;
      lnk_we    = 1'b0;
      lnk_wa    = prev_ff;
      lnk_wd    = '0;
      cmp_a     = hint_ff;
      cmp_b     = now_ff;
      do_unlink = 1'b0;

      load      = 1'b0;
      ld_status = ST_OK;
      ld_ticks  = '0;
      ld_fired  = 1'b0;
      ld_slot   = '0;
      ld_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               slot_in  = req_chan.slot;
               exp_in   = TIME_BITS'(req_chan.expiry_time);
               now_in   = TIME_BITS'(req_chan.current_time);
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rd_addr   = sidx;
            status_in = ST_OK;
            ticks_in  = '0;
            cur_in       = head_ff;
            have_prev_in = 1'b0;
            cnt_in       = '0;
            held_valid_in = 1'b0;
            state_in  = S_RESP;
            case (cmd_type'(cmd_ff))
               CMD_ATTACH: begin
                  if (!slot_ok) begin
                     status_in = ST_ERR;
                  end else begin
                     attached_in[sidx] = 1'b1;
                  end
               end
               CMD_MODIFY: begin
                  if (!slot_ok || !attached_ff[sidx]) begin
                     status_in = ST_ERR;
                  end else if (armed_ff[sidx]) begin
                     status_in = ST_PEND;
                     state_in  = S_MOD_CMP;
                  end else begin
                     state_in = S_MOD_HINT;
                  end
               end
               CMD_DELETE: begin
                  if (!slot_ok) begin
                     status_in = ST_ERR;
                  end else if (armed_ff[sidx]) begin
                     mode_in  = WK_REMOVE;
                     state_in = S_WALK_RD;
                  end
               end
               CMD_RUN: begin
                  lrt_in = now_ff;
                  cmp_b  = now_ff;
                  if (!tbl_empty && !cmp_after) begin
                     mode_in  = WK_RUN;
                     state_in = S_WALK_RD;
                  end
               end
               CMD_QUERY: begin
                  cmp_b = lrt_ff;
                  if (tbl_empty) begin
                     status_in = ST_ERR;
                  end else if (!cmp_after) begin
                     // hint is stale: rebuild from the horizon
                     hint_in  = lrt_ff + HALF;
                     mode_in  = WK_MIN;
                     state_in = S_WALK_RD;
                  end else begin
                     state_in = S_TICKS;
                  end
               end
               CMD_PURGE: begin
                  armed_in = '0;
               end
               default: begin
                  status_in = ST_ERR;
               end
            endcase
         end

         S_MOD_CMP: begin
            // same expiry while armed leaves the order alone
            if (exp_rd == exp_ff) begin
               state_in = S_RESP;
            end else begin
               mode_in  = WK_REMOVE;
               state_in = S_WALK_RD;
            end
         end

         S_WALK_RD: begin
            if (!cur_ok || cnt_ff == CW'(NUM_SLOTS) || !armed_ff[cur_ff]) begin
               case (mode_ff)
                  WK_REMOVE: state_in = S_REM_HINT;
                  WK_RUN:    state_in = S_RUN_END;
                  default:   state_in = S_TICKS;
               endcase
            end else begin
               state_in = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            case (mode_ff)
               WK_REMOVE: begin
                  if (cur_ff == sidx) begin
                     do_unlink  = 1'b1;
                     old_exp_in = exp_rd;
                     state_in   = S_REM_HINT;
                  end else begin
                     prev_in      = cur_ff;
                     have_prev_in = 1'b1;
                     cur_in       = lnk_rd;
                     cnt_in       = cnt_ff + 1'b1;
                     state_in     = is_tail ? S_REM_HINT : S_WALK_RD;
                  end
               end
               WK_RUN: begin
                  cmp_a = exp_rd;
                  cmp_b = now_ff;
                  if (!cmp_after && held_valid_ff && !out_free) begin
                     state_in = S_WALK_CHK;
                  end else begin
                     if (!cmp_after) begin
                        // expired: pass the held fire on, hold this one
                        do_unlink     = 1'b1;
                        load          = held_valid_ff;
                        ld_fired      = 1'b1;
                        ld_slot       = 5'(held_slot_ff);
                        ld_last       = 1'b0;
                        held_valid_in = 1'b1;
                        held_slot_in  = cur_ff;
                     end else begin
                        prev_in      = cur_ff;
                        have_prev_in = 1'b1;
                     end
                     cur_in   = lnk_rd;
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = is_tail ? S_RUN_END : S_WALK_RD;
                  end
               end
               default: begin
                  cmp_b = exp_rd;
                  if (cmp_after) begin
                     hint_in = exp_rd;
                  end
                  cur_in   = lnk_rd;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = is_tail ? S_TICKS : S_WALK_RD;
               end
            endcase
         end

         S_REM_HINT: begin
            if (hint_ff == old_exp_ff) begin
               hint_in = lrt_ff;
            end
            armed_in[sidx] = 1'b0;
            state_in = (cmd_type'(cmd_ff) == CMD_MODIFY) ? S_MOD_HINT : S_RESP;
         end

         S_MOD_HINT: begin
            exp_we = 1'b1;
            cmp_b  = exp_ff;
            if (cmp_after) begin
               hint_in = exp_ff;
            end
            state_in = S_APPEND1;
         end

         S_APPEND1: begin
            if (tbl_empty) begin
               head_in = sidx;
            end else begin
               lnk_we = 1'b1;
               lnk_wa = tail_ff;
               lnk_wd = sidx;
            end
            tail_in  = sidx;
            state_in = S_APPEND2;
         end

         S_APPEND2: begin
            lnk_we = 1'b1;
            lnk_wa = sidx;
            lnk_wd = '0;
            armed_in[sidx] = 1'b1;
            state_in = S_RESP;
         end

         S_RUN_END: begin
            if (out_free) begin
               load     = 1'b1;
               ld_fired = held_valid_ff;
               ld_slot  = held_valid_ff ? 5'(held_slot_ff) : 5'd0;
               state_in = S_IDLE;
            end
         end

         S_TICKS: begin
            // distance from now to the hint, clamped at zero and saturated
            cmp_a = now_ff;
            cmp_b = hint_ff;
            if (cmp_after) begin
               ticks_in = '0;
            end else if (span > 64'(TICKS_MAX)) begin
               ticks_in = TICKS_MAX;
            end else begin
               ticks_in = TICKS_W'(span);
            end
            status_in = ST_OK;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = status_ff;
               ld_ticks  = ticks_ff;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // unlink the slot at cur from the arming list
      if (do_unlink) begin
         armed_in[cur_ff] = 1'b0;
         if (!have_prev_ff) begin
            if (!is_tail) begin
               head_in = lnk_rd;
            end
         end else begin
            lnk_we = 1'b1;
            lnk_wa = prev_ff;
            lnk_wd = is_tail ? '0 : lnk_rd;
            if (is_tail) begin
               tail_in = prev_ff;
            end
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= WK_REMOVE;
         held_valid_ff <= 1'b0;
         attached_ff   <= '0;
         armed_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         lrt_ff        <= '0;
         hint_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         attached_ff   <= attached_in;
         armed_ff      <= armed_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         lrt_ff        <= lrt_in;
         hint_ff       <= hint_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      exp_ff       <= exp_in;
      now_ff       <= now_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      cnt_ff       <= cnt_in;
      held_slot_ff <= held_slot_in;
      old_exp_ff   <= old_exp_in;
      status_ff    <= status_in;
      ticks_ff     <= ticks_in;
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_ticks_ff  <= ld_ticks;
         rsp_fired_ff  <= ld_fired;
         rsp_slot_ff   <= ld_slot;
         rsp_last_ff   <= ld_last;
      end
   end
endmodule

/* design/ett_checker.sv */
// port-level checks for the expiry timer table and their binding
`include "assert_macros.svh"

module ett_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [30:0] rsp_ticks_left,
   input logic        rsp_fired
);
   `ASSERT_CLK_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)
   `ASSERT_CLK(a_fired_clean, clock, reset,
      rsp_valid && rsp_fired |-> rsp_status == 2'd0 && rsp_ticks_left == 31'd0)
endmodule

bind expiry_timer_table ett_checker u_ett_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_ticks_left (rsp_chan.ticks_left),
   .rsp_fired      (rsp_chan.fired)
);

/* sim/tb_top.sv */
// self-checking testbench of the expiry timer table: a scoreboard predicts every response word
`timescale 1ns / 1ps

module tb_top import ett_pkg::*; ();

   // unused command codes; the block must reject them
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam logic [31:0] HORIZON   = 32'h7fff_ffff;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_WORDS = 500;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] ticks_left;
      logic        fired;
      logic [4:0]  fired_slot;
      logic        last;
   } rsp_word_type;

   // timer table shadow and the queue of response words still owed by the block
   class timer_scoreboard;
      bit          attached [32];
      bit          armed [32];
      bit [31:0]   expiry [32];
      bit [4:0]    link [32];
      bit [4:0]    head;
      bit [4:0]    tail;
      bit [31:0]   last_run;
      bit [31:0]   hint;
      bit [4:0]    chain [$];
      rsp_word_type owed [$];
      int          fails;

      function bit later(bit [31:0] a, bit [31:0] b);
         return (b - a) > HORIZON;
      endfunction

      function bit none_armed();
         foreach (armed[i])
            if (armed[i])
               return 0;
         return 1;
      endfunction

      // arming order from head to tail
      function void walk_chain();
         int s;
         chain.delete();
         if (none_armed())
            return;
         s = head;
         while (chain.size() < 32 && armed[s]) begin
            chain.push_back(5'(s));
            if (s == tail)
               break;
            s = link[s];
         end
      endfunction

      function void unlink(bit [4:0] s);
         int n;
         walk_chain();
         n = chain.size();
         for (int i = 0; i < n; i++) begin
            if (chain[i] != s)
               continue;
            if (i == 0) begin
               if (i + 1 < n)
                  head = chain[i+1];
            end else begin
               link[chain[i-1]] = (i + 1 < n) ? chain[i+1] : 5'd0;
               if (i + 1 == n)
                  tail = chain[i-1];
            end
            break;
         end
         armed[s] = 0;
      endfunction

      function void append(bit [4:0] s);
         if (none_armed())
            head = s;
         else
            link[tail] = s;
         tail = s;
         link[s] = 0;
         armed[s] = 1;
      endfunction

      function void owe(logic [1:0] st, logic [30:0] tk, logic fd, logic [4:0] fs,
                        logic lst);
         rsp_word_type w;
         w.status = st;
         w.ticks_left = tk;
         w.fired = fd;
         w.fired_slot = fs;
         w.last = lst;
         owed.push_back(w);
      endfunction

      // one accepted request word: work out every response word it causes
      function void note_request(logic [2:0] cmd, logic [4:0] slot, logic [31:0] exp,
                                 logic [31:0] now);
         bit [4:0]  snap [$];
         bit [31:0] d;
         bit        was;
         int        k;
         case (cmd)
            CMD_ATTACH: begin
               attached[slot] = 1;
               owe(ST_OK, 0, 0, 0, 1);
            end
            CMD_MODIFY: begin
               if (!attached[slot]) begin
                  owe(ST_ERR, 0, 0, 0, 1);
               end else if (armed[slot] && expiry[slot] == exp) begin
                  owe(ST_PEND, 0, 0, 0, 1);
               end else begin
                  was = armed[slot];
                  if (was) begin
                     unlink(slot);
                     if (hint == expiry[slot])
                        hint = last_run;
                  end
                  expiry[slot] = exp;
                  if (later(hint, exp))
                     hint = exp;
                  append(slot);
                  owe(was ? ST_PEND : ST_OK, 0, 0, 0, 1);
               end
            end
            CMD_DELETE: begin
               if (armed[slot]) begin
                  unlink(slot);
                  if (hint == expiry[slot])
                     hint = last_run;
               end
               owe(ST_OK, 0, 0, 0, 1);
            end
            CMD_RUN: begin
               last_run = now;
               k = 0;
               if (!none_armed() && !later(hint, now)) begin
                  walk_chain();
                  snap = chain;
                  foreach (snap[i]) begin
                     if (later(expiry[snap[i]], now))
                        continue;
                     unlink(snap[i]);
                     owe(ST_OK, 0, 1, snap[i], 0);
                     k++;
                  end
               end
               if (k == 0)
                  owe(ST_OK, 0, 0, 0, 1);
               else
                  owed[owed.size()-1].last = 1;
            end
            CMD_QUERY: begin
               if (none_armed()) begin
                  owe(ST_ERR, 0, 0, 0, 1);
               end else begin
                  // stale hint: rebuild from the armed slots
                  if (!later(hint, last_run)) begin
                     hint = last_run + HORIZON;
                     walk_chain();
                     foreach (chain[i])
                        if (later(hint, expiry[chain[i]]))
                           hint = expiry[chain[i]];
                  end
                  d = hint - now;
                  if (d > HORIZON)
                     d = 0;
                  owe(ST_OK, d[30:0], 0, 0, 1);
               end
            end
            CMD_PURGE: begin
               foreach (armed[i])
                  armed[i] = 0;
               owe(ST_OK, 0, 0, 0, 1);
            end
            default: owe(ST_ERR, 0, 0, 0, 1);
         endcase
      endfunction

      function void cmp(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            fails++;
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (owed.size() == 0) begin
            $error("response word with none expected");
            fails++;
            return;
         end
         want = owed.pop_front();
         cmp("status", want.status, got.status);
         cmp("ticks_left", want.ticks_left, got.ticks_left);
         cmp("fired", want.fired, got.fired);
         cmp("fired_slot", want.fired_slot, got.fired_slot);
         cmp("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   ett_req_if req_chan ();
   ett_rsp_if rsp_chan ();

   timer_scoreboard timers;
   bit       no_idle;        // stretch without gaps on either side
   bit [31:0] base_tick;     // running notion of the present time
   int       quiet_cycles;

   expiry_timer_table DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("expiry_timer_table verification failed");
         $finish;
      end
   end

   // response side: random stall before each word, then check it
   initial begin : rsp_side
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid)
            @(posedge clock);
         timers.check_response({rsp_chan.status, rsp_chan.ticks_left, rsp_chan.fired,
                                rsp_chan.fired_slot, rsp_chan.last});
         @(negedge clock);
      end
   end

   // send one request word; entered and left at a falling edge
   task automatic send(logic [2:0] cmd, logic [4:0] slot, logic [31:0] exp,
                       logic [31:0] now);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.slot <= slot;
      req_chan.expiry_time <= exp;
      req_chan.current_time <= now;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      timers.note_request(cmd, slot, exp, now);
      @(negedge clock);
   endtask

   // expiry near the present time, now and then anywhere in the range
   function automatic logic [31:0] pick_expiry();
      if ($urandom_range(0, 9) == 0)
         return $urandom;
      return base_tick + $urandom_range(0, 150);
   endfunction

   task automatic random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         send(CMD_ATTACH, 5'($urandom_range(0, 31)), $urandom, $urandom);
      else if (pick < 50)
         send(CMD_MODIFY, 5'($urandom_range(0, 31)), pick_expiry(), $urandom);
      else if (pick < 60)
         send(CMD_DELETE, 5'($urandom_range(0, 31)), $urandom, $urandom);
      else if (pick < 80) begin
         base_tick = base_tick + $urandom_range(0, 60);
         send(CMD_RUN, 5'($urandom), $urandom,
              ($urandom_range(0, 19) == 0) ? $urandom : base_tick);
      end else if (pick < 96)
         send(CMD_QUERY, 5'($urandom), $urandom,
              ($urandom_range(0, 9) == 0) ? $urandom : base_tick + $urandom_range(0, 40));
      else if (pick < 98)
         send(CMD_PURGE, 5'($urandom), $urandom, $urandom);
      else
         send(pick[0] ? CMD_SPARE7 : CMD_SPARE6, 5'($urandom), $urandom, $urandom);
   endtask

   initial begin
      timers = new();
      no_idle = 0;
      base_tick = 32'h0000_1000;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_ATTACH;
      req_chan.slot = '0;
      req_chan.expiry_time = '0;
      req_chan.current_time = '0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every command and the corner cases
      send(CMD_QUERY, 0, 0, 0);                        // query on empty table
      send(CMD_RUN, 0, 0, 32'hffff_ffff);              // run with nothing armed
      send(CMD_MODIFY, 5, 32'h10, 0);                  // modify before attach
      send(CMD_ATTACH, 0, 0, 0);
      send(CMD_ATTACH, 31, 32'hffff_ffff, 32'hffff_ffff);
      send(CMD_ATTACH, 5, 0, 0);
      send(CMD_MODIFY, 0, 32'h0000_0000, 0);
      send(CMD_MODIFY, 0, 32'h0000_0000, 0);           // same expiry while armed
      send(CMD_MODIFY, 31, 32'hffff_ffff, 0);
      send(CMD_MODIFY, 5, 32'h7fff_ffff, 0);
      send(CMD_QUERY, 0, 0, 32'h8000_0000);            // expiry already passed
      send(CMD_MODIFY, 0, 32'h0000_0100, 0);           // modify that makes this slot the hinted one
      send(CMD_QUERY, 0, 0, 32'hffff_fff0);
      send(CMD_DELETE, 0, 0, 0);                       // delete of the hinted slot
      send(CMD_DELETE, 0, 0, 0);                       // delete of an idle slot
      send(CMD_QUERY, 0, 0, 32'h0000_0000);            // saturated distance
      send(CMD_RUN, 0, 0, 32'h0000_0001);
      send(CMD_MODIFY, 0, 32'h0000_0002, 0);
      send(CMD_RUN, 0, 0, 32'h8000_0000);              // several fire in one run
      send(CMD_MODIFY, 31, 32'h8000_0100, 0);
      send(CMD_PURGE, 0, 0, 0);
      send(CMD_QUERY, 0, 0, 0);
      send(CMD_SPARE6, 0, 0, 0);
      send(CMD_SPARE7, 31, 32'hffff_ffff, 32'hffff_ffff);

      // random: attach most slots early so modifies get through
      base_tick = $urandom;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 60 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if (i < 40)
            send(CMD_ATTACH, 5'($urandom_range(0, 31)), $urandom, $urandom);
         else
            random_word();
      end
      req_chan.valid <= 1'b0;

      while (timers.owed.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (timers.fails == 0)
         $display("expiry_timer_table verification clean");
      else
         $display("expiry_timer_table verification failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/ett_pkg.sv
design/ett_req_if.sv
design/ett_tcmp.sv
design/ett_store.sv
design/expiry_timer_table.sv
design/ett_checker.sv
sim/tb_top.sv
